// ===== design/h4_hci_packet_deframer_core_assert.svh =====
// Assertion macros used by the deframer phase machine (h4d_fsm).
`ifndef H4_HCI_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define H4_HCI_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define H4D_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed");

// Next-cycle implication, checked while out of reset.
`define H4D_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed");

`endif

// ===== design/h4d_pkg.sv =====
package h4d_pkg;

   localparam logic [7:0] TYPE_ACL   = 8'h02;
   localparam logic [7:0] TYPE_SCO   = 8'h03;
   localparam logic [7:0] TYPE_EVENT = 8'h04;

   localparam int EVENT_TOTAL_HDR = 3;
   localparam int SCO_TOTAL_HDR   = 4;
   localparam int ACL_TOTAL_HDR   = 5;
   localparam int HIGH_SHIFT      = 8;

   localparam logic [2:0] EVENT_HDR_BYTES = 3'(EVENT_TOTAL_HDR - 1);
   localparam logic [2:0] SCO_HDR_BYTES   = 3'(SCO_TOTAL_HDR - 1);
   localparam logic [2:0] ACL_HDR_BYTES   = 3'(ACL_TOTAL_HDR - 1);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_kind;
      logic       first_of_packet;
      logic       last_of_packet;
      logic       bad_type;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

// ===== design/h4d_in_stage.sv =====
module h4d_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       take,
   output logic       item_valid,
   output logic [7:0] item_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         byte_ff <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item_byte  = byte_ff;

endmodule

// ===== design/h4d_fsm.sv =====
`include "h4_hci_packet_deframer_core_assert.svh"

module h4d_fsm (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  logic [7:0]          item_byte,
   input  logic                out_free,
   output logic                take,
   output h4d_pkg::result_type result
);

   typedef enum logic [1:0] {
      PH_TYPE    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_EVENT = 2'd0,
      KIND_ACL   = 2'd1,
      KIND_SCO   = 2'd2
   } kind_type;

   phase_type   phase_ff;
   phase_type   phase_in;
   kind_type    kind_ff;
   kind_type    kind_in;
   logic [2:0]  hpos_ff;
   logic [2:0]  hpos_in;
   logic [7:0]  len_lo_ff;
   logic [7:0]  len_lo_in;
   logic [15:0] remain_ff;
   logic [15:0] remain_in;
   logic [15:0] remain_hdr;
   logic [2:0]  hdr_bytes;
   logic        fwd_kind;
   logic        first;
   logic        last;

   assign take     = item_valid && out_free;
   assign fwd_kind = (kind_ff == KIND_EVENT) || (kind_ff == KIND_ACL);

   always_comb begin
      unique case (kind_ff)
         KIND_EVENT: hdr_bytes = h4d_pkg::EVENT_HDR_BYTES;
         KIND_ACL:   hdr_bytes = h4d_pkg::ACL_HDR_BYTES;
         default:    hdr_bytes = h4d_pkg::SCO_HDR_BYTES;
      endcase
   end

   always_comb begin
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      hpos_in     = hpos_ff;
      len_lo_in   = len_lo_ff;
      remain_in   = remain_ff;
      remain_hdr  = remain_ff;
      first       = 1'b0;
      last        = 1'b0;
      result      = '0;
      if (take) begin
         unique case (phase_ff)
            PH_HEADER: begin
               first = (hpos_ff == 3'd0);
               unique case (kind_ff)
                  KIND_EVENT: begin
                     if (hpos_ff == 3'd1) remain_hdr = {8'd0, item_byte};
                  end
                  KIND_ACL: begin
                     if (hpos_ff == 3'd2) begin
                        len_lo_in = item_byte;
                     end else if (hpos_ff == 3'd3) begin
                        remain_hdr = (16'(item_byte) << h4d_pkg::HIGH_SHIFT) |
                                     16'(len_lo_ff);
                     end
                  end
                  default: begin
                     if (hpos_ff == 3'd2) remain_hdr = {8'd0, item_byte};
                  end
               endcase
               remain_in = remain_hdr;
               hpos_in   = hpos_ff + 3'd1;
               if (hpos_in >= hdr_bytes) begin
                  if (remain_hdr == 16'd0) begin
                     last     = 1'b1;
                     phase_in = PH_TYPE;
                  end else begin
                     phase_in = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               remain_in = remain_ff - 16'd1;
               if (remain_in == 16'd0) begin
                  last     = 1'b1;
                  phase_in = PH_TYPE;
               end
            end
            default: begin
               phase_in = PH_TYPE;
               if (item_byte == h4d_pkg::TYPE_EVENT || item_byte == h4d_pkg::TYPE_ACL ||
                   item_byte == h4d_pkg::TYPE_SCO) begin
                  if (item_byte == h4d_pkg::TYPE_EVENT) begin
                     kind_in = KIND_EVENT;
                  end else if (item_byte == h4d_pkg::TYPE_ACL) begin
                     kind_in = KIND_ACL;
                  end else begin
                     kind_in = KIND_SCO;
                  end
                  hpos_in   = 3'd0;
                  len_lo_in = 8'd0;
                  remain_in = 16'd0;
                  phase_in  = PH_HEADER;
               end else begin
                  result.valid         = 1'b1;
                  result.data.bad_type = 1'b1;
               end
            end
         endcase
         if ((phase_ff == PH_HEADER || phase_ff == PH_PAYLOAD) && fwd_kind) begin
            result.valid                = 1'b1;
            result.data.out_byte        = item_byte;
            result.data.packet_kind     = (kind_ff == KIND_ACL);
            result.data.first_of_packet = first;
            result.data.last_of_packet  = last;
            result.data.bad_type        = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TYPE;
         kind_ff   <= KIND_EVENT;
         hpos_ff   <= 3'd0;
         len_lo_ff <= 8'd0;
         remain_ff <= 16'd0;
      end else begin
         phase_ff  <= phase_in;
         kind_ff   <= kind_in;
         hpos_ff   <= hpos_in;
         len_lo_ff <= len_lo_in;
         remain_ff <= remain_in;
      end
   end

   `H4D_ASSERT_NOW(a_bad_clean, result.valid && result.data.bad_type, result.data.out_byte == 8'd0 && !result.data.first_of_packet && !result.data.last_of_packet && !result.data.packet_kind)
   `H4D_ASSERT_NOW(a_payload_nonzero, phase_ff == PH_PAYLOAD, remain_ff != 16'd0)
   `H4D_ASSERT_NOW(a_hdr_in_range, phase_ff == PH_HEADER, hpos_ff < hdr_bytes)
   `H4D_ASSERT_NEXT(a_last_ends, take && last, phase_ff == PH_TYPE)

endmodule

// ===== design/h4d_out_stage.sv =====
module h4d_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  h4d_pkg::result_type result,
   output logic                out_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast,
   output logic [2:0]          rsp_tuser
);

   logic             valid_ff;
   logic             valid_in;
   h4d_pkg::rsp_type data_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (result.valid) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (result.valid) begin
         data_ff <= result.data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff.out_byte;
   assign rsp_tlast  = data_ff.last_of_packet;
   assign rsp_tuser  = {data_ff.bad_type, data_ff.first_of_packet, data_ff.packet_kind};

endmodule

// ===== design/h4_hci_packet_deframer_core.sv =====
// Splits a received UART byte stream into H4 HCI packets. Each request is one
// byte; the type byte selects event, ACL or SCO framing and is never forwarded.
// Event and ACL header and payload bytes come out one per response with the
// packet kind and first/last marks; SCO packets produce nothing, and an unknown
// type byte produces one response with bad_type set and all data fields zero.
// One byte is taken every cycle while the response side accepts: the phase
// machine updates its state between the input register and the output register,
// so a response passes through both registers, and throughput is limited
// only by backpressure on the response side.
module h4_hci_packet_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast,
   output logic [2:0] rsp_tuser    // [0] packet_kind, [1] first_of_packet, [2] bad_type
);

   logic                item_valid;
   logic [7:0]          item_byte;
   logic                take;
   logic                out_free;
   h4d_pkg::result_type result;

   h4d_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (take),
      .item_valid (item_valid),
      .item_byte  (item_byte)
   );

   h4d_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_byte  (item_byte),
      .out_free   (out_free),
      .take       (take),
      .result     (result)
   );

   h4d_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
